// ===== sv/dapm_pkg.sv =====
`timescale 1ns / 1ps

package dapm_pkg;

	// Field widths
	localparam int POSITION_WIDTH   = 32;
	localparam int GAIN_FRAC_BITS   = 8;
	localparam int GAIN_WIDTH       = 12;
	localparam int LIMIT_WIDTH      = 8;
	localparam int DIRECT_WIDTH     = 9;
	localparam int FUNC_WIDTH       = 2;
	localparam int AXIS_DRIVE_WIDTH = LIMIT_WIDTH + 1;
	localparam int DRIVE_WIDTH      = AXIS_DRIVE_WIDTH + 1;

	// Configuration port
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = GAIN_WIDTH;

	// Stream payloads, packed from bit 0 and padded to whole bytes
	localparam int S_FIELDS_WIDTH = 2 * DIRECT_WIDTH + 4 * POSITION_WIDTH;
	localparam int S_TDATA_WIDTH  = ((S_FIELDS_WIDTH + 7) / 8) * 8;
	localparam int M_FIELDS_WIDTH = 2 * DRIVE_WIDTH;
	localparam int M_TDATA_WIDTH  = ((M_FIELDS_WIDTH + 7) / 8) * 8;

	// Mode codes; the spare code runs the closed loop like polar
	typedef enum logic [FUNC_WIDTH-1:0] {
		FUNC_STOP   = 2'd0,
		FUNC_DIRECT = 2'd1,
		FUNC_POLAR  = 2'd2
	} func_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_KP_DISTANCE    = 3'd0,
		REG_KD_DISTANCE    = 3'd1,
		REG_KP_ROTATION    = 3'd2,
		REG_KD_ROTATION    = 3'd3,
		REG_LIMIT_DISTANCE = 3'd4,
		REG_LIMIT_ROTATION = 3'd5,
		REG_ENABLE_DIST    = 3'd6,
		REG_ENABLE_ROT     = 3'd7
	} cfg_reg_t;

	// Per-axis settings handed to the PD unit
	typedef struct packed {
		logic [GAIN_WIDTH-1:0]  kp;
		logic [GAIN_WIDTH-1:0]  kd;
		logic [LIMIT_WIDTH-1:0] limit;
		logic                   enable;
	} axis_cfg_t;

endpackage

// ===== sv/dapm_axis.sv =====
`timescale 1ns / 1ps

// PD law on one axis: (kp*e + kd*(e - e_prev)) / 2^F, truncated toward zero,
// zeroed when disabled, clamped to +-limit.
module dapm_axis (
	input  logic signed [dapm_pkg::POSITION_WIDTH-1:0]   err,
	input  logic signed [dapm_pkg::POSITION_WIDTH-1:0]   prev,
	input  dapm_pkg::axis_cfg_t                          cfg,
	output logic signed [dapm_pkg::AXIS_DRIVE_WIDTH-1:0] drive
);

	localparam int PW     = dapm_pkg::POSITION_WIDTH;
	localparam int FRAC   = dapm_pkg::GAIN_FRAC_BITS;
	localparam int PROD_W = PW + dapm_pkg::GAIN_WIDTH + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam int Q_W    = SUM_W - FRAC;
	localparam int DW     = dapm_pkg::AXIS_DRIVE_WIDTH;

	logic signed [PW-1:0]     diff;
	logic signed [PROD_W-1:0] p_term;
	logic signed [PROD_W-1:0] d_term;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  biased;
	logic signed [Q_W-1:0]    q;
	logic signed [Q_W-1:0]    lim_pos;
	logic signed [Q_W-1:0]    lim_neg;

	// error change wraps at the position width
	assign diff   = err - prev;
	assign p_term = PROD_W'(err) * PROD_W'($signed({1'b0, cfg.kp}));
	assign d_term = PROD_W'(diff) * PROD_W'($signed({1'b0, cfg.kd}));
	assign sum    = SUM_W'(p_term) + SUM_W'(d_term);

	// bias negatives so the arithmetic shift rounds toward zero
	assign biased = sum[SUM_W-1] ? sum + SUM_W'((1 << FRAC) - 1) : sum;
	assign q      = Q_W'(biased >>> FRAC);

	assign lim_pos = Q_W'(cfg.limit);
	assign lim_neg = -lim_pos;

	always_comb begin
		priority if (!cfg.enable) begin
			drive = '0;
		end else if (q > lim_pos) begin
			drive = DW'(lim_pos);
		end else if (q < lim_neg) begin
			drive = DW'(lim_neg);
		end else begin
			drive = DW'(q);
		end
	end

endmodule

// ===== sv/dual_axis_pd_motor_mixer_top.sv =====
`timescale 1ns / 1ps

// Dual-axis PD motor mixer for a differential-drive base. Each request on the
// slave stream is one control tick and yields exactly one request on the master
// stream. Mode (tuser) stop drives both motors with zero, direct passes the two
// direct values through, and polar (or the spare code) runs a PD law on the
// distance and rotation errors, then mixes them into left = d + r and
// right = d - r. Previous errors are updated only by closed-loop ticks, also
// when an axis is disabled. A request goes from one input register to one
// result register that offers it; a new request is taken every cycle while
// the master stream does not stall. Between the two registers the four 32x13
// multiplies with their add, round and clamp are combinational. The stored
// errors are written as an item enters the result register, for the next one.
// Write configuration only while the block holds no request.
module dual_axis_pd_motor_mixer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [dapm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [dapm_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	// slave stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// direct_left, direct_right, target_distance, measured_distance,
	// target_rotation, measured_rotation, zero pad
	input  logic [dapm_pkg::S_TDATA_WIDTH-1:0]    s_axis_tdata,
	// func
	input  logic [dapm_pkg::FUNC_WIDTH-1:0]       s_axis_tuser,
	// master stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// drive_left, drive_right, zero pad
	output logic [dapm_pkg::M_TDATA_WIDTH-1:0]    m_axis_tdata
);

	localparam int PW = dapm_pkg::POSITION_WIDTH;
	localparam int DI = dapm_pkg::DIRECT_WIDTH;
	localparam int DW = dapm_pkg::DRIVE_WIDTH;
	localparam int AW = dapm_pkg::AXIS_DRIVE_WIDTH;
	localparam int GW = dapm_pkg::GAIN_WIDTH;
	localparam int LW = dapm_pkg::LIMIT_WIDTH;

	// bit offsets within slave tdata
	localparam int OFS_DR = DI;
	localparam int OFS_TD = 2 * DI;
	localparam int OFS_MD = OFS_TD + PW;
	localparam int OFS_TR = OFS_MD + PW;
	localparam int OFS_MR = OFS_TR + PW;

	// Configuration registers
	logic [GW-1:0] kp_dist_q, kd_dist_q, kp_rot_q, kd_rot_q;
	logic [LW-1:0] limit_dist_q, limit_rot_q;
	logic          en_dist_q, en_rot_q;

	// Stored errors from the last closed-loop tick
	logic signed [PW-1:0] last_dist_err_q, last_rot_err_q;

	// Input register
	logic                                valid_s1;
	logic [dapm_pkg::FUNC_WIDTH-1:0]     func_s1;
	logic signed [DI-1:0]                dl_s1, dr_s1;
	logic signed [PW-1:0]                td_s1, md_s1, tr_s1, mr_s1;

	// Result register
	logic                                valid_s2;
	logic signed [DW-1:0]                left_s2, right_s2;

	logic                                advance;
	logic                                is_stop, is_direct, is_loop;
	logic signed [PW-1:0]                err_dist, err_rot;
	logic signed [AW-1:0]                drive_dist, drive_rot;
	logic signed [DW-1:0]                left_d, right_d;
	dapm_pkg::axis_cfg_t                 cfg_dist, cfg_rot;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_dist_q    <= '0;
			kd_dist_q    <= '0;
			kp_rot_q     <= '0;
			kd_rot_q     <= '0;
			limit_dist_q <= LW'(127);
			limit_rot_q  <= LW'(50);
			en_dist_q    <= 1'b1;
			en_rot_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (dapm_pkg::cfg_reg_t'(cfg_index))
				dapm_pkg::REG_KP_DISTANCE:    kp_dist_q    <= cfg_data[GW-1:0];
				dapm_pkg::REG_KD_DISTANCE:    kd_dist_q    <= cfg_data[GW-1:0];
				dapm_pkg::REG_KP_ROTATION:    kp_rot_q     <= cfg_data[GW-1:0];
				dapm_pkg::REG_KD_ROTATION:    kd_rot_q     <= cfg_data[GW-1:0];
				dapm_pkg::REG_LIMIT_DISTANCE: limit_dist_q <= cfg_data[LW-1:0];
				dapm_pkg::REG_LIMIT_ROTATION: limit_rot_q  <= cfg_data[LW-1:0];
				dapm_pkg::REG_ENABLE_DIST:    en_dist_q    <= cfg_data[0];
				dapm_pkg::REG_ENABLE_ROT:     en_rot_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance the input register whenever the result register is free or
	// being drained; take a new request in the same cycle.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1 <= s_axis_tuser;
			dl_s1   <= s_axis_tdata[DI-1:0];
			dr_s1   <= s_axis_tdata[OFS_DR +: DI];
			td_s1   <= s_axis_tdata[OFS_TD +: PW];
			md_s1   <= s_axis_tdata[OFS_MD +: PW];
			tr_s1   <= s_axis_tdata[OFS_TR +: PW];
			mr_s1   <= s_axis_tdata[OFS_MR +: PW];
		end
	end

	// Mode decode; anything other than stop or direct is closed loop
	assign is_stop   = (func_s1 == dapm_pkg::FUNC_STOP);
	assign is_direct = (func_s1 == dapm_pkg::FUNC_DIRECT);
	assign is_loop   = !is_stop && !is_direct;

	// Errors wrap at the position width
	assign err_dist = td_s1 - md_s1;
	assign err_rot  = tr_s1 - mr_s1;

	assign cfg_dist = '{kp: kp_dist_q, kd: kd_dist_q, limit: limit_dist_q, enable: en_dist_q};
	assign cfg_rot  = '{kp: kp_rot_q, kd: kd_rot_q, limit: limit_rot_q, enable: en_rot_q};

	dapm_axis u_axis_dist (
		.err   (err_dist),
		.prev  (last_dist_err_q),
		.cfg   (cfg_dist),
		.drive (drive_dist)
	);

	dapm_axis u_axis_rot (
		.err   (err_rot),
		.prev  (last_rot_err_q),
		.cfg   (cfg_rot),
		.drive (drive_rot)
	);

	// Select the drive pair for this tick
	always_comb begin
		priority if (is_stop) begin
			left_d  = '0;
			right_d = '0;
		end else if (is_direct) begin
			left_d  = DW'(dl_s1);
			right_d = DW'(dr_s1);
		end else begin
			left_d  = DW'(drive_dist) + DW'(drive_rot);
			right_d = DW'(drive_dist) - DW'(drive_rot);
		end
	end

	// Result register valid and stored errors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2        <= 1'b0;
			last_dist_err_q <= '0;
			last_rot_err_q  <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
			// closed-loop ticks only, even with an axis disabled
			if (advance && is_loop) begin
				last_dist_err_q <= err_dist;
				last_rot_err_q  <= err_rot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s2  <= left_d;
			right_s2 <= right_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = dapm_pkg::M_TDATA_WIDTH'({right_s2, left_s2});

	// A free result register never holds back the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// Stop ticks give zero drive on both motors
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_stop |=> (left_s2 == '0) && (right_s2 == '0))
		else $error("stop tick gave non-zero drive");

	// Stop and direct ticks leave the stored errors alone
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_loop |=> $stable(last_dist_err_q) && $stable(last_rot_err_q))
		else $error("stored error changed outside closed loop");

	// Both axes disabled: closed-loop ticks drive nothing
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_loop && !en_dist_q && !en_rot_q
		|=> (left_s2 == '0) && (right_s2 == '0))
		else $error("disabled axes gave non-zero drive");

	// The mix is symmetric: left + right is twice the distance drive, so even
	a_mix_even: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_loop |=> ((left_s2[0] ^ right_s2[0]) == 1'b0))
		else $error("left and right drive parity mismatch");

endmodule
